// ----- rtl/core/sstf_pkg.sv -----
package sstf_pkg;

    // Field widths of one request and of one served result
    localparam int ARRIVAL_W = 16;
    localparam int TRACK_W   = 12;
    localparam int SECTOR_W  = 8;
    localparam int REQNUM_W  = 5;
    localparam int SEEK_W    = 16;
    localparam int SEARCH_W  = 14;
    localparam int XFER_W    = 8;
    localparam int TOTAL_W   = 17;
    localparam int CLOCK_W   = 24;
    localparam int TIME10_W  = ARRIVAL_W + 4;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHEDULE_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_BASE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_PER_TRACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_PER_SECTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_COST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_TRACK = 3'd5;

    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_SSTF = 1'b1;

    localparam int MAX_REQUESTS_DEF = 16;

    // One stored request
    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [TRACK_W-1:0]   track;
        logic [SECTOR_W-1:0]  sector;
    } req_entry_t;

    // Scheduler sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST_RD,
        ST_FIRST_LD,
        ST_NEXT,
        ST_FC_RD,
        ST_FC_LD,
        ST_ADM_RD,
        ST_ADM_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SEEK,
        ST_SUM,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/core/sstf_req_mem.sv -----
module sstf_req_mem
    import sstf_pkg::*;
#(
    parameter int DEPTH  = MAX_REQUESTS_DEF,
    parameter int ADDR_W = $clog2(MAX_REQUESTS_DEF)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  req_entry_t        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output req_entry_t        rd_data
);

    req_entry_t mem [DEPTH];

    // Write one request per load beat
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/sstf_dist_unit.sv -----
module sstf_dist_unit
    import sstf_pkg::*;
(
    input  logic [TRACK_W-1:0] track_a,
    input  logic [TRACK_W-1:0] track_b,
    input  logic [TRACK_W-1:0] best,
    output logic [TRACK_W-1:0] trk_dist,
    output logic               closer
);

    // Absolute head distance, then compare against the best so far
    always_comb
    begin
        if (track_a > track_b)
        begin
            trk_dist = track_a - track_b;
        end
        else
        begin
            trk_dist = track_b - track_a;
        end
        closer = (trk_dist < best);
    end

endmodule

// ----- rtl/core/sstf_disk_request_scheduler.sv -----
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// in       | in_valid/in_ready  | arrival_time, track, sector, last_request
// out      | out_valid/out_ready| request_number .. finish_time, last_result
// cfg      | cfg_wr_en          | cfg_index, cfg_data
//
// Loading accepts one request per cycle. The last request starts a schedule that
// emits one result per stored request; the first request is read in ST_FIRST_RD
// and ST_FIRST_LD, costed in ST_SEEK and made valid in ST_SUM. In first-come mode
// each further result passes ST_NEXT, ST_FC_RD, ST_FC_LD, ST_SEEK and ST_SUM. In
// shortest-seek mode ST_ADM_RD and ST_ADM_CMP admit each arrived request or one
// reached by a clock jump, a check short of the loaded count ends admission, and
// the nearest-track scan through the single request-memory read port skips served
// entries and compares pending ones below the admit pointer. in_ready is low while
// a batch is being scheduled. A stalled result holds the sequencer in place. Reset
// clears the batch state and loads the register defaults; memory is not cleared.
module sstf_disk_request_scheduler
    import sstf_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ARRIVAL_W-1:0]  arrival_time,
    input  logic [TRACK_W-1:0]    track,
    input  logic [SECTOR_W-1:0]   sector,
    input  logic                  last_request,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [REQNUM_W-1:0]   request_number,
    output logic [TRACK_W-1:0]    served_track,
    output logic [SECTOR_W-1:0]   served_sector,
    output logic [SEEK_W-1:0]     seek_time,
    output logic [SEARCH_W-1:0]   search_time,
    output logic [XFER_W-1:0]     transfer_part,
    output logic [TOTAL_W-1:0]    total_time,
    output logic [CLOCK_W-1:0]    finish_time,
    output logic                  last_result
);

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    // Configuration registers
    logic                 mode_reg;
    logic [9:0]           seek_base_reg;
    logic [3:0]           seek_per_track_reg;
    logic [5:0]           search_per_sector_reg;
    logic [XFER_W-1:0]    transfer_cost_reg;
    logic [7:0]           sectors_per_track_reg;

    // Sequencer and batch state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [CNT_W-1:0]     ap_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic [MAX_REQUESTS-1:0] served_reg;
    logic                 fresh_reg;
    logic                 found_reg;
    logic [TRACK_W-1:0]   best_reg;
    logic [TRACK_W-1:0]   head_track_reg;
    logic [SECTOR_W-1:0]  head_sector_reg;
    logic [CLOCK_W-1:0]   clock_reg;

    // Candidate request and partial costs
    logic [IDX_W-1:0]     cand_idx_reg;
    logic [TRACK_W-1:0]   cand_track_reg;
    logic [SECTOR_W-1:0]  cand_sector_reg;
    logic [SEEK_W-1:0]    seek_reg;
    logic [SEARCH_W-1:0]  search_reg;

    // Output register
    logic                 out_valid_reg;
    logic [REQNUM_W-1:0]  request_number_reg;
    logic [TRACK_W-1:0]   served_track_reg;
    logic [SECTOR_W-1:0]  served_sector_reg;
    logic [SEEK_W-1:0]    seek_time_reg;
    logic [SEARCH_W-1:0]  search_time_reg;
    logic [XFER_W-1:0]    transfer_part_reg;
    logic [TOTAL_W-1:0]   total_time_reg;
    logic [CLOCK_W-1:0]   finish_time_reg;
    logic                 last_result_reg;

    // Memory and shared unit connections
    logic                 mem_wr_en;
    req_entry_t           mem_wr_data;
    logic [IDX_W-1:0]     mem_rd_addr;
    req_entry_t           mem_q;
    logic [TRACK_W-1:0]   dist_a;
    logic [TRACK_W-1:0]   trk_dist;
    logic                 closer;

    // Derived values
    logic                 in_beat;
    logic                 out_beat;
    logic                 store_full;
    logic [TIME10_W-1:0]  arr_tenths;
    logic                 arrived;
    logic                 none_pending;
    logic                 scan_served;
    logic [7:0]           slots;
    logic signed [9:0]    wrap_s;
    logic [TOTAL_W-1:0]   total_sum;
    logic [CLOCK_W:0]     clock_sum;
    logic [CLOCK_W-1:0]   clock_sat;
    logic [31:0]          reqnum_full;

    assign in_beat      = in_valid && in_ready;
    assign out_beat     = out_valid_reg && out_ready;
    assign store_full   = (count_reg == CNT_W'(MAX_REQUESTS));
    assign arr_tenths   = (TIME10_W'(mem_q.arrival) << 3) + (TIME10_W'(mem_q.arrival) << 1);
    assign arrived      = (CLOCK_W'(arr_tenths) <= clock_reg);
    assign none_pending = (k_reg == ap_reg);
    assign scan_served  = served_reg[scan_reg[IDX_W-1:0]];

    assign mem_wr_en   = in_beat && !store_full;
    assign mem_wr_data = '{arrival: arrival_time, track: track, sector: sector};

    sstf_req_mem #(
        .DEPTH  (MAX_REQUESTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_q)
    );

    // Share one distance unit between the scan and the seek stage
    assign dist_a = (state_reg == ST_SCAN_CMP) ? mem_q.track : cand_track_reg;

    sstf_dist_unit u_dist (
        .track_a  (dist_a),
        .track_b  (head_track_reg),
        .best     (best_reg),
        .trk_dist (trk_dist),
        .closer   (closer)
    );

    // Rotational slots between the head sector and the candidate sector
    always_comb
    begin
        wrap_s = signed'({2'b00, sectors_per_track_reg}) - signed'({2'b00, head_sector_reg})
                 - 10'sd1 + signed'({2'b00, cand_sector_reg});
        if (fresh_reg)
        begin
            slots = cand_sector_reg;
        end
        else if (cand_sector_reg > head_sector_reg)
        begin
            slots = cand_sector_reg - head_sector_reg - 8'd1;
        end
        else if (cand_sector_reg < head_sector_reg)
        begin
            slots = wrap_s[9] ? 8'd0 : wrap_s[7:0];
        end
        else
        begin
            slots = 8'd0;
        end
    end

    // Total cost and saturating clock
    always_comb
    begin
        total_sum   = TOTAL_W'(seek_reg) + TOTAL_W'(search_reg) + TOTAL_W'(transfer_cost_reg);
        clock_sum   = (CLOCK_W + 1)'(clock_reg) + (CLOCK_W + 1)'(total_sum);
        clock_sat   = clock_sum[CLOCK_W] ? CLOCK_MAX : clock_sum[CLOCK_W-1:0];
        reqnum_full = 32'(cand_idx_reg) + 32'd1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && last_request)
                begin
                    state_next = ST_FIRST_RD;
                end
            end
            ST_FIRST_RD: state_next = ST_FIRST_LD;
            ST_FIRST_LD: state_next = ST_SEEK;
            ST_NEXT:
            begin
                state_next = (mode_reg == MODE_FCFS) ? ST_FC_RD : ST_ADM_RD;
            end
            ST_FC_RD:    state_next = ST_FC_LD;
            ST_FC_LD:    state_next = ST_SEEK;
            ST_ADM_RD:
            begin
                state_next = (ap_reg < count_reg) ? ST_ADM_CMP : ST_SCAN_RD;
            end
            ST_ADM_CMP:
            begin
                if (arrived || none_pending)
                begin
                    state_next = ST_ADM_RD;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (scan_reg >= ap_reg)
                begin
                    state_next = ST_SEEK;
                end
                else if (!scan_served)
                begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: state_next = ST_SCAN_RD;
            ST_SEEK:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    state_next = last_result_reg ? ST_IDLE : ST_NEXT;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        mem_rd_addr = '0;
        case (state_reg)
            ST_IDLE:     in_ready    = 1'b1;
            ST_FC_RD:    mem_rd_addr = k_reg[IDX_W-1:0];
            ST_ADM_RD:   mem_rd_addr = ap_reg[IDX_W-1:0];
            ST_SCAN_RD:  mem_rd_addr = scan_reg[IDX_W-1:0];
            default:     mem_rd_addr = '0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg              <= MODE_SSTF;
            seek_base_reg         <= 10'd120;
            seek_per_track_reg    <= 4'd1;
            search_per_sector_reg <= 6'd5;
            transfer_cost_reg     <= 8'd12;
            sectors_per_track_reg <= 8'd10;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SCHEDULE_MODE:     mode_reg              <= cfg_data[0];
                CFG_SEEK_BASE:         seek_base_reg         <= cfg_data;
                CFG_SEEK_PER_TRACK:    seek_per_track_reg    <= cfg_data[3:0];
                CFG_SEARCH_PER_SECTOR: search_per_sector_reg <= cfg_data[5:0];
                CFG_TRANSFER_COST:     transfer_cost_reg     <= cfg_data[7:0];
                CFG_SECTORS_PER_TRACK: sectors_per_track_reg <= cfg_data[7:0];
                default:               mode_reg              <= mode_reg;
            endcase
        end
    end

    // Batch control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            k_reg           <= '0;
            ap_reg          <= '0;
            scan_reg        <= '0;
            served_reg      <= '0;
            fresh_reg       <= 1'b1;
            found_reg       <= 1'b0;
            head_track_reg  <= '0;
            head_sector_reg <= '0;
            clock_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (mem_wr_en)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ST_FIRST_LD:
                begin
                    ap_reg <= CNT_W'(1);
                end
                ST_FC_LD:
                begin
                    // Wait for the arrival in first-come order
                    if (!arrived)
                    begin
                        clock_reg <= CLOCK_W'(arr_tenths);
                    end
                end
                ST_ADM_RD:
                begin
                    scan_reg  <= '0;
                    found_reg <= 1'b0;
                end
                ST_ADM_CMP:
                begin
                    // Admit, or idle the clock forward to the next arrival
                    if (arrived)
                    begin
                        ap_reg <= ap_reg + CNT_W'(1);
                    end
                    else if (none_pending)
                    begin
                        clock_reg <= CLOCK_W'(arr_tenths);
                        ap_reg    <= ap_reg + CNT_W'(1);
                    end
                end
                ST_SCAN_RD:
                begin
                    if (scan_reg < ap_reg && scan_served)
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end
                ST_SCAN_CMP:
                begin
                    if (!found_reg || closer)
                    begin
                        found_reg <= 1'b1;
                    end
                    scan_reg <= scan_reg + CNT_W'(1);
                end
                ST_SUM:
                begin
                    clock_reg                  <= clock_sat;
                    head_track_reg             <= cand_track_reg;
                    head_sector_reg            <= cand_sector_reg;
                    fresh_reg                  <= 1'b0;
                    served_reg[cand_idx_reg]   <= 1'b1;
                    out_valid_reg              <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (out_beat)
                    begin
                        out_valid_reg <= 1'b0;
                        // Drop the batch after its last result
                        if (last_result_reg)
                        begin
                            count_reg       <= '0;
                            k_reg           <= '0;
                            ap_reg          <= '0;
                            served_reg      <= '0;
                            fresh_reg       <= 1'b1;
                            head_track_reg  <= '0;
                            head_sector_reg <= '0;
                            clock_reg       <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    found_reg <= found_reg;
                end
            endcase
        end
    end

    // Candidate, cost stages and output payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_FIRST_LD:
            begin
                cand_idx_reg    <= '0;
                cand_track_reg  <= mem_q.track;
                cand_sector_reg <= mem_q.sector;
            end
            ST_FC_LD:
            begin
                cand_idx_reg    <= k_reg[IDX_W-1:0];
                cand_track_reg  <= mem_q.track;
                cand_sector_reg <= mem_q.sector;
            end
            ST_SCAN_CMP:
            begin
                // Keep the nearest track; ties stay with the lower index
                if (!found_reg || closer)
                begin
                    best_reg        <= trk_dist;
                    cand_idx_reg    <= scan_reg[IDX_W-1:0];
                    cand_track_reg  <= mem_q.track;
                    cand_sector_reg <= mem_q.sector;
                end
            end
            ST_SEEK:
            begin
                seek_reg   <= SEEK_W'(seek_base_reg)
                              + SEEK_W'(seek_per_track_reg) * SEEK_W'(trk_dist);
                search_reg <= SEARCH_W'(slots) * SEARCH_W'(search_per_sector_reg);
            end
            ST_SUM:
            begin
                request_number_reg <= reqnum_full[REQNUM_W-1:0];
                served_track_reg   <= cand_track_reg;
                served_sector_reg  <= cand_sector_reg;
                seek_time_reg      <= seek_reg;
                search_time_reg    <= search_reg;
                transfer_part_reg  <= transfer_cost_reg;
                total_time_reg     <= total_sum;
                finish_time_reg    <= clock_sat;
                last_result_reg    <= (k_reg + CNT_W'(1) == count_reg);
            end
            default:
            begin
                seek_reg <= seek_reg;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign request_number = request_number_reg;
    assign served_track   = served_track_reg;
    assign served_sector  = served_sector_reg;
    assign seek_time      = seek_time_reg;
    assign search_time    = search_time_reg;
    assign transfer_part  = transfer_part_reg;
    assign total_time     = total_time_reg;
    assign finish_time    = finish_time_reg;
    assign last_result    = last_result_reg;

endmodule
